>>> rtl/rpea_pkg.sv
// ----------------------------------------------------------------------------
// rpea_pkg
// Shared types and constants for the register pool extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpea_pkg;

  localparam int MAX_EXTENTS = 32;
  localparam int POOL_DEPTH  = 2048;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int VAL_W       = 12;

  localparam logic [VAL_W-1:0] VAL_MAX  = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] POOL_CAP = VAL_W'(POOL_DEPTH);

  // extent [lo, hi)
  typedef struct packed {
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] lo;
  } ext_t;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_REINIT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD_RNG  = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_POOL_SIZE = 1'b0,
    CFG_GRANULE   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_REINIT,
    S_ROUND,
    S_SCAN_RD,
    S_SCAN_EV,
    S_QDIV,
    S_FREE_ACT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quo;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/rpea_div.sv
// ----------------------------------------------------------------------------
// rpea_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpea_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rpea_pkg::div_req_t req,
  output rpea_pkg::div_rsp_t      rsp
);

  localparam int W = rpea_pkg::VAL_W;

  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         quo_r, quo_nxt;
  logic [W-1:0]         den_r, den_nxt;
  logic [$clog2(W+1)-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [W:0]           trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = ($clog2(W+1))'(W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 1) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> rtl/rpea_ext_ram.sv
// ----------------------------------------------------------------------------
// rpea_ext_ram
// Extent table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rpea_ext_ram (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [rpea_pkg::IDX_W-1:0]   waddr,
  input  wire rpea_pkg::ext_t               wdata,
  input  wire logic [rpea_pkg::IDX_W-1:0]   raddr,
  output rpea_pkg::ext_t                    rdata
);

  rpea_pkg::ext_t mem [rpea_pkg::MAX_EXTENTS];
  rpea_pkg::ext_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/register_pool_extent_allocator.sv
// Sequence: a rejected size or range goes straight to the result; reinit rewrites the table;
//   query/allocate first round the size to the granule, then a query divides each extent, while
//   allocate/free scan the extents (free then writes its update); a removal moves later entries down.
// Throughput: one transaction at a time; the next is taken once the previous is done,
//   set by the extent RAM scan and the 12-step divider.
// Reset: synchronous, active low; the init state after reset writes extent 0 = [0, 2048).
// ----------------------------------------------------------------------------
// register_pool_extent_allocator
// First-fit free-extent allocator with coalescing free, over an extent RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module register_pool_extent_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transaction
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] req_size, [18:12] region_count, [29:19] first_index, [41:30] last_index
  input  wire logic [47:0] in_tdata,
  // [1:0] command
  input  wire logic [1:0]  in_tuser,
  // result transaction
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] status, [13:3] start_index, [25:14] granted_size,
  // [37:26] chunk_count, [49:38] space_left
  output logic [55:0]      out_tdata,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [11:0] cfg_data
);

  localparam int W  = rpea_pkg::VAL_W;
  localparam int IW = rpea_pkg::IDX_W;
  localparam int CW = rpea_pkg::CNT_W;

  rpea_pkg::state_t  state_r, state_nxt;

  // config
  logic [W-1:0] pool_size_r, gran_r;

  // pool state
  logic [CW-1:0] count_r, count_nxt;
  logic [W-1:0]  free_r, free_nxt;

  // captured transaction
  rpea_pkg::cmd_t cmd_r, cmd_nxt;
  logic [W-1:0]   size_r, size_nxt;
  logic [6:0]     regions_r, regions_nxt;
  logic [10:0]    first_r, first_nxt;
  logic [W-1:0]   last_r, last_nxt;

  // work registers
  logic [CW-1:0]  k_r, k_nxt;
  logic [W-1:0]   rounded_r, rounded_nxt;
  logic [W-1:0]   chunks_r, chunks_nxt;
  rpea_pkg::status_t status_r, status_nxt;
  logic [10:0]    start_r, start_nxt;
  logic [W-1:0]   granted_r, granted_nxt;
  logic           fi_hit_r, fi_hit_nxt, li_hit_r, li_hit_nxt;
  logic [IW-1:0]  fi_r, fi_nxt, li_r, li_nxt;
  logic [W-1:0]   fi_lo_r, fi_lo_nxt, li_hi_r, li_hi_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic [55:0]    out_data_r, out_data_nxt;

  // RAM and divider
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  rpea_pkg::ext_t    ram_wdata, ram_rdata;
  rpea_pkg::div_req_t div_req;
  rpea_pkg::div_rsp_t div_rsp;

  // derived values
  logic [W-1:0] eff_pool, gran_eff, ext_len, ext_len_raw;
  logic [W:0]   chunk_sum, free_sum;
  logic [W-1:0] span;

  rpea_ext_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpea_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign eff_pool    = (pool_size_r > rpea_pkg::POOL_CAP) ? rpea_pkg::POOL_CAP : pool_size_r;
  assign gran_eff    = (gran_r == '0) ? W'(1) : gran_r;
  assign ext_len_raw = ram_rdata.hi - ram_rdata.lo;
  assign ext_len     = (ram_rdata.hi > ram_rdata.lo) ? ext_len_raw : '0;
  assign chunk_sum   = {1'b0, chunks_r} + {1'b0, div_rsp.quo};
  assign span        = last_r - {1'b0, first_r};
  assign free_sum    = {1'b0, free_r} + {1'b0, span};

  assign in_tready = (state_r == rpea_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpea_pkg::S_INIT:   state_nxt = rpea_pkg::S_IDLE;
      rpea_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (rpea_pkg::cmd_t'(in_tuser))
            rpea_pkg::CMD_QUERY, rpea_pkg::CMD_ALLOC: begin
              if (in_tdata[11:0] == '0 || in_tdata[11:0] > eff_pool)
                state_nxt = rpea_pkg::S_DONE;
              else
                state_nxt = rpea_pkg::S_ROUND;
            end
            rpea_pkg::CMD_FREE: begin
              if ({1'b0, in_tdata[29:19]} >= in_tdata[41:30])
                state_nxt = rpea_pkg::S_DONE;
              else
                state_nxt = rpea_pkg::S_SCAN_RD;
            end
            default: state_nxt = rpea_pkg::S_REINIT;
          endcase
        end
      end
      rpea_pkg::S_REINIT: state_nxt = rpea_pkg::S_DONE;
      rpea_pkg::S_ROUND: begin
        if (div_rsp.done) state_nxt = rpea_pkg::S_SCAN_RD;
      end
      rpea_pkg::S_SCAN_RD: begin
        if (k_r == count_r)
          state_nxt = (cmd_r == rpea_pkg::CMD_FREE) ? rpea_pkg::S_FREE_ACT : rpea_pkg::S_DONE;
        else
          state_nxt = rpea_pkg::S_SCAN_EV;
      end
      rpea_pkg::S_SCAN_EV: begin
        case (cmd_r)
          rpea_pkg::CMD_QUERY: state_nxt = rpea_pkg::S_QDIV;
          rpea_pkg::CMD_ALLOC: begin
            if (ext_len == rounded_r)     state_nxt = rpea_pkg::S_SHIFT_RD;
            else if (ext_len > rounded_r) state_nxt = rpea_pkg::S_DONE;
            else                          state_nxt = rpea_pkg::S_SCAN_RD;
          end
          default: state_nxt = rpea_pkg::S_SCAN_RD;
        endcase
      end
      rpea_pkg::S_QDIV: begin
        if (div_rsp.done) state_nxt = rpea_pkg::S_SCAN_RD;
      end
      rpea_pkg::S_FREE_ACT: begin
        if (fi_hit_r && li_hit_r && fi_r != li_r) state_nxt = rpea_pkg::S_SHIFT_RD;
        else                                      state_nxt = rpea_pkg::S_DONE;
      end
      rpea_pkg::S_SHIFT_RD: begin
        if (k_r + 1'b1 >= count_r) state_nxt = rpea_pkg::S_DONE;
        else                       state_nxt = rpea_pkg::S_SHIFT_WR;
      end
      rpea_pkg::S_SHIFT_WR: state_nxt = rpea_pkg::S_SHIFT_RD;
      rpea_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = rpea_pkg::S_IDLE;
      end
      default: state_nxt = rpea_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt   = count_r;
    free_nxt    = free_r;
    cmd_nxt     = cmd_r;
    size_nxt    = size_r;
    regions_nxt = regions_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    k_nxt       = k_r;
    rounded_nxt = rounded_r;
    chunks_nxt  = chunks_r;
    status_nxt  = status_r;
    start_nxt   = start_r;
    granted_nxt = granted_r;
    fi_hit_nxt  = fi_hit_r;
    li_hit_nxt  = li_hit_r;
    fi_nxt      = fi_r;
    li_nxt      = li_r;
    fi_lo_nxt   = fi_lo_r;
    li_hi_nxt   = li_hi_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = k_r[IW-1:0];
    div_req     = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      rpea_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{hi: rpea_pkg::POOL_CAP, lo: '0};
      end
      rpea_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = rpea_pkg::cmd_t'(in_tuser);
          size_nxt    = in_tdata[11:0];
          regions_nxt = in_tdata[18:12];
          first_nxt   = in_tdata[29:19];
          last_nxt    = in_tdata[41:30];
          k_nxt       = '0;
          chunks_nxt  = '0;
          start_nxt   = '0;
          granted_nxt = '0;
          fi_hit_nxt  = 1'b0;
          li_hit_nxt  = 1'b0;
          status_nxt  = rpea_pkg::ST_OK;
          case (rpea_pkg::cmd_t'(in_tuser))
            rpea_pkg::CMD_QUERY, rpea_pkg::CMD_ALLOC: begin
              if (in_tdata[11:0] == '0 || in_tdata[11:0] > eff_pool)
                status_nxt = rpea_pkg::ST_BAD_SIZE;
              else begin
                div_req = '{start: 1'b1, num: in_tdata[11:0], den: gran_eff};
                status_nxt = rpea_pkg::ST_NO_SPACE;
              end
            end
            rpea_pkg::CMD_FREE: begin
              if ({1'b0, in_tdata[29:19]} >= in_tdata[41:30])
                status_nxt = rpea_pkg::ST_BAD_RNG;
            end
            default: ;
          endcase
        end
      end
      rpea_pkg::S_REINIT: begin
        ram_we    = (eff_pool != '0);
        ram_wdata = '{hi: eff_pool, lo: '0};
        count_nxt = (eff_pool != '0) ? CW'(1) : '0;
        free_nxt  = eff_pool;
      end
      rpea_pkg::S_ROUND: begin
        // size rounded up to the granule from the remainder of size / granule, as the divider finishes
        if (div_rsp.done)
          rounded_nxt = (div_rsp.rem != '0) ? W'(size_r + gran_eff - div_rsp.rem) : size_r;
      end
      rpea_pkg::S_SCAN_RD: begin
        if (k_r == count_r && cmd_r == rpea_pkg::CMD_QUERY)
          status_nxt = ({5'd0, regions_r} <= chunks_r) ? rpea_pkg::ST_OK
                                                     : rpea_pkg::ST_NO_SPACE;
      end
      rpea_pkg::S_SCAN_EV: begin
        case (cmd_r)
          rpea_pkg::CMD_QUERY: begin
            div_req = '{start: 1'b1, num: ext_len, den: rounded_r};
          end
          rpea_pkg::CMD_ALLOC: begin
            if (ext_len >= rounded_r) begin
              // first fit: grant from the front
              status_nxt  = rpea_pkg::ST_OK;
              start_nxt   = ram_rdata.lo[10:0];
              granted_nxt = rounded_r;
              free_nxt    = (free_r > rounded_r) ? W'(free_r - rounded_r) : '0;
              if (ext_len != rounded_r) begin
                ram_we    = 1'b1;
                ram_waddr = k_r[IW-1:0];
                ram_wdata = '{hi: ram_rdata.hi, lo: W'(ram_rdata.lo + rounded_r)};
              end
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
          default: begin
            if (!fi_hit_r && ram_rdata.hi == {1'b0, first_r}) begin
              fi_hit_nxt = 1'b1;
              fi_nxt     = k_r[IW-1:0];
              fi_lo_nxt  = ram_rdata.lo;
            end
            if (!li_hit_r && ram_rdata.lo == last_r) begin
              li_hit_nxt = 1'b1;
              li_nxt     = k_r[IW-1:0];
              li_hi_nxt  = ram_rdata.hi;
            end
            k_nxt = k_r + 1'b1;
          end
        endcase
      end
      rpea_pkg::S_QDIV: begin
        if (div_rsp.done) begin
          chunks_nxt = chunk_sum[W] ? rpea_pkg::VAL_MAX : chunk_sum[W-1:0];
          k_nxt      = k_r + 1'b1;
        end
      end
      rpea_pkg::S_FREE_ACT: begin
        if (!fi_hit_r && !li_hit_r && count_r >= CW'(rpea_pkg::MAX_EXTENTS)) begin
          status_nxt = rpea_pkg::ST_FULL;
        end else begin
          free_nxt = free_sum[W] ? rpea_pkg::VAL_MAX : free_sum[W-1:0];
          ram_we   = 1'b1;
          if (fi_hit_r && li_hit_r && fi_r != li_r) begin
            // bridge two extents, then drop the upper one
            ram_waddr = fi_r;
            ram_wdata = '{hi: li_hi_r, lo: fi_lo_r};
            k_nxt     = CW'(li_r);
          end else if (fi_hit_r) begin
            ram_waddr = fi_r;
            ram_wdata = '{hi: last_r, lo: fi_lo_r};
          end else if (li_hit_r) begin
            ram_waddr = li_r;
            ram_wdata = '{hi: li_hi_r, lo: {1'b0, first_r}};
          end else begin
            ram_waddr = count_r[IW-1:0];
            ram_wdata = '{hi: last_r, lo: {1'b0, first_r}};
            count_nxt = count_r + 1'b1;
          end
        end
      end
      rpea_pkg::S_SHIFT_RD: begin
        ram_raddr = IW'(k_r + 1'b1);
        if (k_r + 1'b1 >= count_r) count_nxt = count_r - 1'b1;
      end
      rpea_pkg::S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_r + 1'b1;
      end
      rpea_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, free_r, chunks_r, granted_r, start_r, status_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpea_pkg::S_INIT;
      pool_size_r <= rpea_pkg::POOL_CAP;
      gran_r      <= W'(4);
      count_r     <= CW'(1);
      free_r      <= rpea_pkg::POOL_CAP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (rpea_pkg::cfg_idx_t'(cfg_addr))
          rpea_pkg::CFG_POOL_SIZE: pool_size_r <= cfg_data;
          default:                 gran_r      <= cfg_data;
        endcase
      end
    end
    cmd_r     <= cmd_nxt;
    size_r    <= size_nxt;
    regions_r <= regions_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    k_r       <= k_nxt;
    rounded_r <= rounded_nxt;
    chunks_r  <= chunks_nxt;
    status_r  <= status_nxt;
    start_r   <= start_nxt;
    granted_r <= granted_nxt;
    fi_hit_r  <= fi_hit_nxt;
    li_hit_r  <= li_hit_nxt;
    fi_r      <= fi_nxt;
    li_r      <= li_nxt;
    fi_lo_r   <= fi_lo_nxt;
    li_hi_r   <= li_hi_nxt;
    out_data_r <= out_data_nxt;
  end

  // table never grows past its depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(rpea_pkg::MAX_EXTENTS))
    else $error("extent count overflow");

  // a refused request reports no grant
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2:0] != rpea_pkg::ST_OK) |->
      (out_data_r[25:3] == '0))
    else $error("grant on failed request");

  // one transaction at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  // table is only written while a transaction is in flight or at init
  a_ram_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpea_pkg::S_IDLE) |-> !ram_we)
    else $error("table write while idle");

endmodule

`default_nettype wire

>>> verif/register_pool_extent_allocator_test.sv
// ----------------------------------------------------------------------------
// register_pool_extent_allocator_test
// Drives query, allocate, free and reinit transactions into the extent
// allocator, predicts every result with a behavioral copy of the extent
// table, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module register_pool_extent_allocator_test;
  import rpea_pkg::*;

  localparam int STALL_MAX   = 18;
  localparam int DRAIN_WAIT  = 3000;   // longest item: query over a full table
  localparam longint CYCLE_LIMIT = 4000000;

  // first member sits in the top bits; status is in the lowest bits of tdata
  typedef struct packed {
    logic [11:0] space_left;
    logic [11:0] chunk_count;
    logic [11:0] granted_size;
    logic [10:0] start_index;
    status_t     status;
  } result_t;

  typedef struct {
    cmd_t        command;
    logic [11:0] req_size;
    logic [6:0]  region_count;
    logic [10:0] first_index;
    logic [11:0] last_index;
  } request_t;

  int error_count;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Scoreboard: holds a copy of the extent table and the queue of results
  // that the block still owes.
  class extent_scoreboard;
    logic [11:0] pool_size;
    logic [11:0] granule;
    logic [11:0] ext_lo[MAX_EXTENTS];
    logic [11:0] ext_hi[MAX_EXTENTS];
    int          n_ext;
    logic [11:0] free_total;
    result_t     owed[$];

    function void reset_state();
      pool_size = 12'd2048;
      granule   = 12'd4;
      restore_pool();
      owed.delete();
    endfunction

    function int unsigned pool_cap();
      return (pool_size > POOL_DEPTH) ? POOL_DEPTH : pool_size;
    endfunction

    function void restore_pool();
      int unsigned p;
      p = pool_cap();
      foreach (ext_lo[i]) begin
        ext_lo[i] = '0;
        ext_hi[i] = '0;
      end
      n_ext = 0;
      if (p > 0) begin
        ext_hi[0] = 12'(p);
        n_ext = 1;
      end
      free_total = 12'(p);
    endfunction

    function void drop_extent(int k);
      for (int i = k; i + 1 < n_ext; i++) begin
        ext_lo[i] = ext_lo[i+1];
        ext_hi[i] = ext_hi[i+1];
      end
      n_ext--;
      ext_lo[n_ext] = '0;
      ext_hi[n_ext] = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [11:0] val);
      if (idx == CFG_POOL_SIZE) pool_size = val;
      else granule = val;
    endfunction

    // note one accepted request and queue the result it must produce
    function void note_request(request_t rq);
      result_t r;
      int unsigned g, rnd, chunks, len, sz, fi, li, ft;
      r = '0;
      r.status = ST_OK;
      chunks = 0;
      g = (granule == 0) ? 1 : granule;
      sz = rq.req_size;
      case (rq.command)
        CMD_QUERY, CMD_ALLOC: begin
          if (sz == 0 || sz > pool_cap()) begin
            r.status = ST_BAD_SIZE;
          end else begin
            rnd = (sz % g) ? sz + (g - sz % g) : sz;
            if (rq.command == CMD_QUERY) begin
              for (int k = 0; k < n_ext; k++) begin
                len = (ext_hi[k] > ext_lo[k]) ? ext_hi[k] - ext_lo[k] : 0;
                chunks += len / rnd;
                if (chunks > 4095) chunks = 4095;
              end
              r.status = (chunks >= rq.region_count) ? ST_OK : ST_NO_SPACE;
            end else begin
              r.status = ST_NO_SPACE;
              for (int k = 0; k < n_ext; k++) begin
                len = (ext_hi[k] > ext_lo[k]) ? ext_hi[k] - ext_lo[k] : 0;
                if (len >= rnd) begin
                  r.start_index  = 11'(ext_lo[k]);
                  r.granted_size = 12'(rnd);
                  free_total = (free_total > rnd) ? 12'(free_total - rnd) : 12'd0;
                  if (len == rnd) drop_extent(k);
                  else ext_lo[k] = 12'(ext_lo[k] + rnd);
                  r.status = ST_OK;
                  break;
                end
              end
            end
          end
        end
        CMD_FREE: begin
          if (rq.first_index >= rq.last_index) begin
            r.status = ST_BAD_RNG;
          end else begin
            fi = MAX_EXTENTS;
            li = MAX_EXTENTS;
            for (int k = 0; k < n_ext; k++) begin
              if (fi == MAX_EXTENTS && ext_hi[k] == rq.first_index) fi = k;
              if (li == MAX_EXTENTS && ext_lo[k] == rq.last_index) li = k;
            end
            if (fi == MAX_EXTENTS && li == MAX_EXTENTS && n_ext >= MAX_EXTENTS) begin
              r.status = ST_FULL;
            end else begin
              if (fi != MAX_EXTENTS && li != MAX_EXTENTS && fi != li) begin
                ext_hi[fi] = ext_hi[li];
                drop_extent(li);
              end else if (fi != MAX_EXTENTS) begin
                ext_hi[fi] = rq.last_index;
              end else if (li != MAX_EXTENTS) begin
                ext_lo[li] = {1'b0, rq.first_index};
              end else begin
                ext_lo[n_ext] = {1'b0, rq.first_index};
                ext_hi[n_ext] = rq.last_index;
                n_ext++;
              end
              ft = free_total + (rq.last_index - rq.first_index);
              free_total = (ft > 4095) ? 12'hFFF : 12'(ft);
            end
          end
        end
        default: restore_pool();
      endcase
      r.chunk_count = 12'(chunks);
      r.space_left  = free_total;
      owed = {owed, r};
    endfunction

    task check_result(result_t got);
      result_t exp;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      exp = owed.pop_front();
      if (got.status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.start_index !== exp.start_index)
        report_mismatch($sformatf("start_index %0d, expected %0d",
                                  got.start_index, exp.start_index));
      if (got.granted_size !== exp.granted_size)
        report_mismatch($sformatf("granted_size %0d, expected %0d",
                                  got.granted_size, exp.granted_size));
      if (got.chunk_count !== exp.chunk_count)
        report_mismatch($sformatf("chunk_count %0d, expected %0d",
                                  got.chunk_count, exp.chunk_count));
      if (got.space_left !== exp.space_left)
        report_mismatch($sformatf("space_left %0d, expected %0d",
                                  got.space_left, exp.space_left));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // req_size, region_count, first_index, last_index
  logic [1:0]  in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // status, start_index, granted_size, chunk_count, space_left
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [11:0] cfg_data;

  register_pool_extent_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  extent_scoreboard sb;
  longint cycle_count;
  bit     hold_off;      // long receiver stall requested by the stimulus
  bit     random_ready;  // receiver stalls at random when set
  bit     tx_live;       // in_tvalid is currently driven high

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // global watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: per transaction it draws a stall, and honors a long hold-off.
  initial begin
    int wait_cycles;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      wait_cycles = random_ready ? $urandom_range(0, STALL_MAX) : 0;
      if (random_ready && $urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles > 0 || hold_off) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      // transaction at this edge
      sb.check_result(result_t'(out_tdata[49:0]));
    end
  end

  // lower in_tvalid once, if it is still up
  task automatic drive_idle();
    if (tx_live) begin
      in_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
  endtask

  // send one request; the prediction is noted at the accepting edge
  task automatic send_request(input request_t rq, input int gap);
    if (gap > 0) begin
      drive_idle();
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= rq.command;
    in_tdata  <= {6'b0, rq.last_index, rq.first_index, rq.region_count, rq.req_size};
    in_tvalid <= 1'b1;
    tx_live = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(rq);
  endtask

  task automatic send_cmd(input cmd_t c, input int sz, input int rc,
                          input int fi, input int li);
    request_t rq;
    rq.command      = c;
    rq.req_size     = 12'(sz);
    rq.region_count = 7'(rc);
    rq.first_index  = 11'(fi);
    rq.last_index   = 12'(li);
    send_request(rq, random_ready ? $urandom_range(0, STALL_MAX) : 0);
  endtask

  // wait for all results, let the block settle, then write a register
  task automatic write_config(input cfg_idx_t idx, input logic [11:0] val);
    drive_idle();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Random mix. Mostly allocate/free pairs drawn from live allocations, so
  // the table fragments and coalesces; the rest is queries, noise and reinit.
  task automatic random_phase(input int n_items);
    int live_lo[$];
    int live_hi[$];
    int pick, sz, lo, hi, j;
    int unsigned cap;
    for (int n = 0; n < n_items; n++) begin
      cap = sb.pool_cap();
      pick = $urandom_range(0, 99);
      sz = (cap > 0) ? $urandom_range(1, (cap > 96) ? 96 : cap) : 1;
      if ($urandom_range(0, 15) == 0) sz = $urandom_range(0, 4095);
      if (pick < 40) begin
        send_cmd(CMD_ALLOC, sz, 0, 0, 0);
        if (sb.owed[$].status == ST_OK) begin
          live_lo = {live_lo, int'(sb.owed[$].start_index)};
          live_hi = {live_hi, int'(sb.owed[$].start_index) + int'(sb.owed[$].granted_size)};
        end
      end else if (pick < 72 && live_lo.size() > 0) begin
        // free a random piece of a live allocation, sometimes only part of it
        j = $urandom_range(0, live_lo.size() - 1);
        lo = live_lo[j];
        hi = live_hi[j];
        live_lo.delete(j);
        live_hi.delete(j);
        if ($urandom_range(0, 3) == 0 && hi - lo > 1) begin
          send_cmd(CMD_FREE, 0, 0, lo + 1, hi);
          live_lo = {live_lo, lo};
          live_hi = {live_hi, lo + 1};
        end else begin
          send_cmd(CMD_FREE, 0, 0, lo, hi);
        end
      end else if (pick < 86) begin
        send_cmd(CMD_QUERY, sz, $urandom_range(0, 127), 0, 0);
      end else if (pick < 97) begin
        // raw noise: any field values, including bad ranges and overlaps
        send_cmd(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 4095),
                 $urandom_range(0, 127), $urandom_range(0, 2047),
                 $urandom_range(0, 4095));
      end else begin
        send_cmd(CMD_REINIT, $urandom_range(0, 4095), $urandom_range(0, 127),
                 $urandom_range(0, 2047), $urandom_range(0, 4095));
        live_lo.delete();
        live_hi.delete();
      end
    end
  endtask

  // Carve the pool into single-granule pieces and free every other one so the
  // table fills; three more isolated frees then hit the table-full case.
  task automatic fill_table();
    send_cmd(CMD_REINIT, 0, 0, 0, 0);
    for (int i = 0; i < 70; i++) send_cmd(CMD_ALLOC, 4, 0, 0, 0);
    for (int i = 0; i < 34; i++) send_cmd(CMD_FREE, 0, 0, i * 8, i * 8 + 4);
    send_cmd(CMD_QUERY, 4, 64, 0, 0);
    send_cmd(CMD_QUERY, 1, 127, 0, 0);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    error_count  = 0;
    hold_off     = 1'b0;
    random_ready = 1'b0;
    tx_live      = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size extremes, every command, special cases
    send_cmd(CMD_QUERY, 0, 1, 0, 0);           // illegal size zero
    send_cmd(CMD_QUERY, 2049, 1, 0, 0);        // above pool
    send_cmd(CMD_QUERY, 4095, 127, 2047, 4095);
    send_cmd(CMD_QUERY, 1, 127, 0, 0);
    send_cmd(CMD_QUERY, 2048, 1, 0, 0);
    send_cmd(CMD_QUERY, 2048, 2, 0, 0);        // no fit
    send_cmd(CMD_ALLOC, 3, 0, 0, 0);           // rounds to 4
    send_cmd(CMD_ALLOC, 2041, 0, 0, 0);        // rounds to 2044, exact fit empties the table
    send_cmd(CMD_ALLOC, 100, 0, 0, 0);
    send_cmd(CMD_FREE, 0, 0, 5, 5);            // empty range
    send_cmd(CMD_FREE, 0, 0, 2047, 0);         // reversed range
    send_cmd(CMD_FREE, 0, 0, 0, 4);            // append to empty table
    send_cmd(CMD_FREE, 0, 0, 4, 104);          // grows the extent that ends at 4
    send_cmd(CMD_FREE, 0, 0, 2047, 4095);      // range past the pool end, appended as a new extent
    send_cmd(CMD_REINIT, 4095, 127, 2047, 4095);
    send_cmd(CMD_ALLOC, 2048, 0, 0, 0);        // exact fit empties the table
    send_cmd(CMD_QUERY, 4, 0, 0, 0);
    send_cmd(CMD_FREE, 0, 0, 0, 16);           // append to empty table
    send_cmd(CMD_REINIT, 0, 0, 0, 0);

    fill_table();

    // long receiver hold-off while the sender keeps going
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++) send_cmd(CMD_ALLOC, 8, 0, 0, 0);
        drive_idle();
      end
    join
    @(posedge clk);

    random_ready = 1'b1;
    random_phase(250);

    write_config(CFG_GRANULE, 12'd0);          // acts as 1
    write_config(CFG_POOL_SIZE, 12'd64);
    send_cmd(CMD_REINIT, 0, 0, 0, 0);
    random_phase(150);

    write_config(CFG_GRANULE, 12'd4095);
    write_config(CFG_POOL_SIZE, 12'd4095);     // capped at pool depth
    send_cmd(CMD_REINIT, 0, 0, 0, 0);
    random_phase(60);

    write_config(CFG_POOL_SIZE, 12'd0);
    send_cmd(CMD_REINIT, 0, 0, 0, 0);
    send_cmd(CMD_QUERY, 1, 0, 0, 0);
    send_cmd(CMD_FREE, 0, 0, 0, 32);
    send_cmd(CMD_ALLOC, 1, 0, 0, 0);

    write_config(CFG_GRANULE, 12'd1);
    write_config(CFG_POOL_SIZE, 12'd1);
    send_cmd(CMD_REINIT, 0, 0, 0, 0);
    random_phase(60);

    write_config(CFG_GRANULE, 12'd2048);
    write_config(CFG_POOL_SIZE, 12'd2048);
    send_cmd(CMD_REINIT, 0, 0, 0, 0);
    random_phase(40);

    write_config(CFG_GRANULE, 12'd8);
    send_cmd(CMD_REINIT, 0, 0, 0, 0);
    random_phase(100);

    drive_idle();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) begin
      @(posedge clk);
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
